/* sv/tef_pkg.sv */
// ----------------------------------------------------------------------------
// Touch event filter package
// Shared constants, register indexes, event codes and the coefficient bundle
// used by the filter top level and its coordinate transform stage.
// ----------------------------------------------------------------------------
package tef_pkg;

	// Default parameter values
	localparam int LONG_TAP_MS_DEF = 450;
	localparam int MAX_FINGERS_DEF = 16;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN_FROM_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN_FROM_X   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SHIFT         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN_FROM_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN_FROM_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SHIFT         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_OFF_SCREEN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_SIZE     = 3'd7;

	// Configuration reset values
	localparam logic signed [31:0] RST_GAIN_UNITY  = 32'sd65536;
	localparam logic signed [31:0] RST_GAIN_ZERO   = 32'sd0;
	localparam logic [31:0]        RST_SCREEN_SIZE = 32'd47187200;

	// Input item type
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Input event kinds
	localparam logic [1:0] KIND_TAP     = 2'd0;
	localparam logic [1:0] KIND_DRAG    = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;
	localparam logic [1:0] KIND_CANCEL  = 2'd3;

	// Output kind for a long tap
	localparam logic [2:0] OUT_KIND_LONG = 3'd4;

	// Affine transform coefficients, all Q16.16
	typedef struct packed {
		logic signed [31:0] x_gain_from_x;
		logic signed [31:0] y_gain_from_x;
		logic signed [31:0] x_shift;
		logic signed [31:0] x_gain_from_y;
		logic signed [31:0] y_gain_from_y;
		logic signed [31:0] y_shift;
	} coef_t;

endpackage

/* sv/tef_in_if.sv */
// ----------------------------------------------------------------------------
// Touch event input channel
// Valid/ready channel that carries one touch event or time tick.
// ----------------------------------------------------------------------------
interface tef_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [3:0]         finger;
	logic [1:0]         kind;
	logic signed [15:0] raw_x;
	logic signed [15:0] raw_y;
	logic [15:0]        elapsed;

	modport source (
		output valid, cmd, finger, kind, raw_x, raw_y, elapsed,
		input  ready
	);

	modport sink (
		input  valid, cmd, finger, kind, raw_x, raw_y, elapsed,
		output ready
	);
endinterface

/* sv/tef_out_if.sv */
// ----------------------------------------------------------------------------
// Touch event output channel
// Valid/ready channel that carries one filtered or long-tap event.
// ----------------------------------------------------------------------------
interface tef_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         out_finger;
	logic [2:0]         out_kind;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;

	modport source (
		output valid, out_finger, out_kind, out_x, out_y,
		input  ready
	);

	modport sink (
		input  valid, out_finger, out_kind, out_x, out_y,
		output ready
	);
endinterface

/* sv/tef_xform.sv */
// ----------------------------------------------------------------------------
// Touch event coordinate transform
// Registers the four Q16.16 products of the affine transform, then sums,
// truncates toward zero and saturates each coordinate to signed 16 bits.
// ----------------------------------------------------------------------------
module tef_xform (
	input  logic               clk,
	input  logic               en,
	input  tef_pkg::coef_t     coef,
	input  logic signed [15:0] raw_x,
	input  logic signed [15:0] raw_y,
	output logic signed [15:0] x,
	output logic signed [15:0] y
);

	// Product registers, one multiplier in front of each
	logic signed [47:0] p_xx_s2;
	logic signed [47:0] p_xy_s2;
	logic signed [47:0] p_yx_s2;
	logic signed [47:0] p_yy_s2;
	logic signed [31:0] x_shift_s2;
	logic signed [31:0] y_shift_s2;

	logic signed [49:0] sum_x;
	logic signed [49:0] sum_y;

	// Divide by 65536 toward zero, then saturate to 16 bits
	function automatic logic signed [15:0] scale_sat(input logic signed [49:0] s);
		logic signed [33:0] q;
		logic signed [15:0] r;
		q = s[49:16];
		if (s[49] && (s[15:0] != 16'd0)) begin
			q = q + 34'sd1;
		end
		if (q > 34'sd32767) begin
			r = 16'sh7fff;
		end else if (q < -34'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = q[15:0];
		end
		return r;
	endfunction

	// Capture products when the item moves into the second stage
	always_ff @(posedge clk) begin
		if (en) begin
			p_xx_s2    <= coef.x_gain_from_x * raw_x;
			p_xy_s2    <= coef.x_gain_from_y * raw_y;
			p_yx_s2    <= coef.y_gain_from_x * raw_x;
			p_yy_s2    <= coef.y_gain_from_y * raw_y;
			x_shift_s2 <= coef.x_shift;
			y_shift_s2 <= coef.y_shift;
		end
	end

	// Sum the terms at full precision
	always_comb begin
		sum_x = {{2{p_xx_s2[47]}}, p_xx_s2} + {{2{p_xy_s2[47]}}, p_xy_s2}
			+ {{18{x_shift_s2[31]}}, x_shift_s2};
		sum_y = {{2{p_yx_s2[47]}}, p_yx_s2} + {{2{p_yy_s2[47]}}, p_yy_s2}
			+ {{18{y_shift_s2[31]}}, y_shift_s2};
	end

	assign x = scale_sat(sum_x);
	assign y = scale_sat(sum_y);

endmodule

/* sv/touch_event_filter_longtap_unit.sv */
// ----------------------------------------------------------------------------
// Touch event filter with long-tap detection
// Transforms touch coordinates, filters off-screen fingers, clamps to the
// screen and reports long taps from time ticks.
// ----------------------------------------------------------------------------
// Path: an accepted transaction passes the input register, the product register
// and the result register before its result is on the output.
// Throughput: one transaction per cycle while results.ready is not holding the
// output; filter state updates in the stage after the product register.
// Reset: clears all valid flags, the ignored-finger mask and long-tap timing,
// and loads the configuration registers with their defaults.
module touch_event_filter_longtap_unit #(
	parameter int LONG_TAP_MS = tef_pkg::LONG_TAP_MS_DEF,
	parameter int MAX_FINGERS = tef_pkg::MAX_FINGERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tef_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tef_pkg::CFG_DATA_W-1:0] cfg_wdata,
	tef_in_if.sink                         events,
	tef_out_if.source                      results
);

	localparam logic [15:0] LONG_TAP_TH = 16'(LONG_TAP_MS);

	// Configuration registers
	tef_pkg::coef_t coef_q;
	logic           drop_q;
	logic [31:0]    screen_q;

	// Stage 1: input register
	logic               v_s1;
	logic               cmd_s1;
	logic [3:0]         finger_s1;
	logic [1:0]         kind_s1;
	logic signed [15:0] raw_x_s1;
	logic signed [15:0] raw_y_s1;
	logic [15:0]        elapsed_s1;

	// Stage 2: products plus control fields
	logic        v_s2;
	logic        cmd_s2;
	logic [3:0]  finger_s2;
	logic [1:0]  kind_s2;
	logic [15:0] elapsed_s2;

	// Filter state
	logic [MAX_FINGERS-1:0] ignored_q;
	logic                   armed_q;
	logic [15:0]            held_time_q;
	logic [3:0]             held_finger_q;
	logic signed [15:0]     held_x_q;
	logic signed [15:0]     held_y_q;

	// Result register
	logic               out_valid_q;
	logic [3:0]         out_finger_q;
	logic [2:0]         out_kind_q;
	logic signed [15:0] out_x_q;
	logic signed [15:0] out_y_q;

	// Stage 2 logic
	logic signed [15:0]     x_s2;
	logic signed [15:0]     y_s2;
	logic signed [16:0]     w_ext;
	logic signed [16:0]     h_ext;
	logic                   outside;
	logic [MAX_FINGERS-1:0] fbit;
	logic                   marked;
	logic [16:0]            tsum_ext;
	logic [15:0]            tsum;
	logic                   long_hit;
	logic                   drop_tap;
	logic                   drop_other;
	logic                   emit_evt;
	logic                   emit;
	logic signed [15:0]     cx;
	logic signed [15:0]     cy;
	logic                   out_free;
	logic                   s2_go;
	logic                   ld2;
	logic                   ld1;

	// Clamp: negative goes to zero, then at or above size goes to size-1
	function automatic logic signed [15:0] clamp_to(
		input logic signed [15:0] v,
		input logic [15:0]        size
	);
		logic signed [16:0] t;
		logic signed [16:0] s;
		t = (v < 16'sd0) ? 17'sd0 : {v[15], v};
		s = {1'b0, size};
		if (t >= s) begin
			t = s - 17'sd1;
		end
		return t[15:0];
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.x_gain_from_x <= tef_pkg::RST_GAIN_UNITY;
			coef_q.y_gain_from_x <= tef_pkg::RST_GAIN_ZERO;
			coef_q.x_shift       <= tef_pkg::RST_GAIN_ZERO;
			coef_q.x_gain_from_y <= tef_pkg::RST_GAIN_ZERO;
			coef_q.y_gain_from_y <= tef_pkg::RST_GAIN_UNITY;
			coef_q.y_shift       <= tef_pkg::RST_GAIN_ZERO;
			drop_q               <= 1'b0;
			screen_q             <= tef_pkg::RST_SCREEN_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tef_pkg::CFG_X_GAIN_FROM_X:   coef_q.x_gain_from_x <= cfg_wdata;
				tef_pkg::CFG_Y_GAIN_FROM_X:   coef_q.y_gain_from_x <= cfg_wdata;
				tef_pkg::CFG_X_SHIFT:         coef_q.x_shift       <= cfg_wdata;
				tef_pkg::CFG_X_GAIN_FROM_Y:   coef_q.x_gain_from_y <= cfg_wdata;
				tef_pkg::CFG_Y_GAIN_FROM_Y:   coef_q.y_gain_from_y <= cfg_wdata;
				tef_pkg::CFG_Y_SHIFT:         coef_q.y_shift       <= cfg_wdata;
				tef_pkg::CFG_DROP_OFF_SCREEN: drop_q               <= cfg_wdata[0];
				tef_pkg::CFG_SCREEN_SIZE:     screen_q             <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Pipeline advance: each stage moves when the one after it has room
	assign out_free = !out_valid_q || results.ready;
	assign s2_go    = v_s2 && (out_free || !emit);
	assign ld2      = !v_s2 || s2_go;
	assign ld1      = !v_s1 || ld2;
	assign events.ready = ld1;

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld1) begin
			v_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && events.valid) begin
			cmd_s1     <= events.cmd;
			finger_s1  <= events.finger;
			kind_s1    <= events.kind;
			raw_x_s1   <= events.raw_x;
			raw_y_s1   <= events.raw_y;
			elapsed_s1 <= events.elapsed;
		end
	end

	// Stage 2 register; the products live in the transform unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2 && v_s1) begin
			cmd_s2     <= cmd_s1;
			finger_s2  <= finger_s1;
			kind_s2    <= kind_s1;
			elapsed_s2 <= elapsed_s1;
		end
	end

	tef_xform u_xform (
		.clk   (clk),
		.en    (ld2 && v_s1),
		.coef  (coef_q),
		.raw_x (raw_x_s1),
		.raw_y (raw_y_s1),
		.x     (x_s2),
		.y     (y_s2)
	);

	// Screen test and finger mask lookup
	always_comb begin
		w_ext   = {1'b0, screen_q[15:0]};
		h_ext   = {1'b0, screen_q[31:16]};
		outside = (x_s2 < 16'sd0) || (y_s2 < 16'sd0)
			|| ({x_s2[15], x_s2} >= w_ext) || ({y_s2[15], y_s2} >= h_ext);
		for (int i = 0; i < MAX_FINGERS; i++) begin
			fbit[i] = ({1'b0, finger_s2} == 5'(i));
		end
		marked = |(ignored_q & fbit);
	end

	// Long-tap timing: saturating sum of tick time
	always_comb begin
		tsum_ext = {1'b0, held_time_q} + {1'b0, elapsed_s2};
		tsum     = tsum_ext[16] ? 16'hffff : tsum_ext[15:0];
		long_hit = armed_q && (tsum >= LONG_TAP_TH);
	end

	// Drop decisions and clamping
	always_comb begin
		drop_tap   = drop_q && (kind_s2 == tef_pkg::KIND_TAP) && outside;
		drop_other = drop_q && (kind_s2 != tef_pkg::KIND_TAP) && marked;
		emit_evt   = !drop_tap && !drop_other;
		if (drop_q && (kind_s2 != tef_pkg::KIND_TAP)) begin
			cx = clamp_to(x_s2, screen_q[15:0]);
			cy = clamp_to(y_s2, screen_q[31:16]);
		end else begin
			cx = x_s2;
			cy = y_s2;
		end
		emit = (cmd_s2 == tef_pkg::CMD_TICK) ? long_hit : emit_evt;
	end

	// Filter state update, once per item leaving stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignored_q     <= '0;
			armed_q       <= 1'b0;
			held_time_q   <= 16'd0;
			held_finger_q <= 4'd0;
			held_x_q      <= 16'sd0;
			held_y_q      <= 16'sd0;
		end else if (s2_go) begin
			if (cmd_s2 == tef_pkg::CMD_TICK) begin
				if (armed_q) begin
					held_time_q <= tsum;
				end
			end else begin
				if (drop_tap) begin
					ignored_q   <= ignored_q | fbit;
					armed_q     <= 1'b0;
					held_time_q <= 16'd0;
				end else if (drop_q && (kind_s2 != tef_pkg::KIND_TAP)
						&& (kind_s2 != tef_pkg::KIND_DRAG)) begin
					ignored_q <= ignored_q & ~fbit;
				end
				if (emit_evt) begin
					held_time_q <= 16'd0;
					if (kind_s2 == tef_pkg::KIND_TAP) begin
						armed_q       <= 1'b1;
						held_finger_q <= finger_s2;
						held_x_q      <= cx;
						held_y_q      <= cy;
					end else begin
						armed_q <= 1'b0;
					end
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s2 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s2 && emit) begin
			if (cmd_s2 == tef_pkg::CMD_TICK) begin
				out_finger_q <= held_finger_q;
				out_kind_q   <= tef_pkg::OUT_KIND_LONG;
				out_x_q      <= held_x_q;
				out_y_q      <= held_y_q;
			end else begin
				out_finger_q <= finger_s2;
				out_kind_q   <= {1'b0, kind_s2};
				out_x_q      <= cx;
				out_y_q      <= cy;
			end
		end
	end

	assign results.valid      = out_valid_q;
	assign results.out_finger = out_finger_q;
	assign results.out_kind   = out_kind_q;
	assign results.out_x      = out_x_q;
	assign results.out_y      = out_y_q;

	// Disarmed timing always carries a zero sum.
	a_disarmed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> (held_time_q == 16'd0))
		else $error("held time nonzero while timing is disarmed");

	// An emitted tap restarts timing from zero.
	a_tap_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && (cmd_s2 == tef_pkg::CMD_EVENT) && (kind_s2 == tef_pkg::KIND_TAP)
			&& emit_evt) |=> (armed_q && (held_time_q == 16'd0)))
		else $error("emitted tap did not arm timing");

	// A tap dropped off screen disarms timing.
	a_drop_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && (cmd_s2 == tef_pkg::CMD_EVENT) && drop_tap) |=> !armed_q)
		else $error("dropped tap left timing armed");

	// An item with a result waits in stage 2 while the result register is blocked.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && emit && !out_free) |=> (v_s2 && $stable(cmd_s2) && $stable(finger_s2)))
		else $error("stage 2 item lost under back-pressure");

endmodule
